@@ sv/smx_pkg.sv @@
// -----------------------------------------------------------------------------
// smx_pkg - shared definitions of the stack machine execute unit
// Request and response types, instruction and error codes, sizes.
// -----------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

   localparam int STACK_DEPTH_DEFAULT = 1024;
   localparam int DATA_W  = 64;
   localparam int CMD_W   = 4;
   localparam int DEPTH_W = 11;
   localparam int ERR_W   = 2;

   localparam logic [CMD_W-1:0] CMD_CONST = 4'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_SUB   = 4'd2;
   localparam logic [CMD_W-1:0] CMD_MUL   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_DIV   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_MAX   = 4'd5;
   localparam logic [CMD_W-1:0] CMD_MIN   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_NEG   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_DUP   = 4'd8;
   localparam logic [CMD_W-1:0] CMD_SWAP  = 4'd9;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_DIVZ  = 2'd3;

   // Value that a pop from an empty stack yields.
   localparam logic [DATA_W-1:0] UNDERFLOW_VALUE = 64'hFFFF_FFFF_F8A4_32EB;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] operand;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic [DEPTH_W-1:0]       stack_depth;
      logic [ERR_W-1:0]         error_code;
   } rsp_type;

endpackage

`default_nettype wire

@@ sv/stack_machine_execute_unit_top.sv @@
// -----------------------------------------------------------------------------
// stack_machine_execute_unit_top - 64-bit stack machine execute unit
// Runs one stack instruction per request on a RAM-held operand stack.
// -----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one response, shown on rsp_data for a single cycle with rsp_valid
// high; the receiver cannot stall it, so it must take the response in that
// cycle. The stack lives in a synchronous RAM of STACK_DEPTH entries; the top
// entry is also kept in a register. While the unit is idle the RAM is read at
// the second entry, and the cycle after acceptance executes, so CONST, ADD,
// SUB, MAX, MIN, NEG, DUP and the unused codes commit in that cycle and their
// response is registered from it. SWAP takes an extra state for its second
// RAM write. MUL goes on from the execute cycle into a multiply state,
// because the 64-bit product is built from three 32 x 32 partial products
// through one shared multiplier. DIV waits in a divide state on an iterative
// divider that yields one quotient bit per cycle; a DIV by zero commits as
// quickly as an ADD. A new request may be given in the cycle in which the
// previous response is shown. The RAM needs no clearing after reset: only
// entries below the depth are ever used.
// -----------------------------------------------------------------------------
`default_nettype none

module stack_machine_execute_unit_top #(
   parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire smx_pkg::req_type req_data,
   output logic                  rsp_valid,
   output smx_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int PW = $clog2(STACK_DEPTH + 1);
   localparam int DW = smx_pkg::DEPTH_W;
   localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_SWAP = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [PW-1:0]         tp_ff, tp_in;
   logic [63:0]           top_ff, top_in;
   logic [3:0]            cmd_ff, cmd_in;
   logic [63:0]           opnd_ff, opnd_in;
   logic [63:0]           a_ff, a_in;
   logic [63:0]           b_ff, b_in;
   logic [PW-1:0]         base_ff, base_in;
   logic [1:0]            err_ff, err_in;
   logic [1:0]            mcnt_ff, mcnt_in;
   logic [63:0]           acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   smx_pkg::rsp_type      rsp_ff, rsp_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [63:0]           wr_data;
   logic [AW-1:0]         rd_addr;
   logic [63:0]           rd_data;
   logic                  div_start;
   logic                  div_done;
   logic [63:0]           div_quo;

   logic                  commit;
   logic [1:0]            commit_err;
   logic                  has1;
   logic                  has2;
   logic [63:0]           a_v;
   logic [63:0]           b_v;
   logic [PW-1:0]         base1;
   logic [PW-1:0]         base2;
   logic [63:0]           alu_r;
   logic [31:0]           mx;
   logic [31:0]           my;
   logic [63:0]           mprod;

   // The second entry is read as the request is accepted.
   assign rd_addr = AW'(tp_ff - PW'(2));

   smx_ram #(
      .WIDTH (64),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   smx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_v),
      .divisor  (b_v),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Operands as seen by the execute cycle; missing entries pop as the
   // underflow value.
   assign has1  = (tp_ff != '0);
   assign has2  = (tp_ff > PW'(1));
   assign a_v   = has1 ? top_ff : smx_pkg::UNDERFLOW_VALUE;
   assign b_v   = has2 ? rd_data : smx_pkg::UNDERFLOW_VALUE;
   assign base1 = has1 ? (tp_ff - PW'(1)) : '0;
   assign base2 = has2 ? (tp_ff - PW'(2)) : '0;

   always_comb begin
      case (cmd_ff)
         smx_pkg::CMD_ADD: alu_r = a_v + b_v;
         smx_pkg::CMD_SUB: alu_r = a_v - b_v;
         smx_pkg::CMD_MAX: alu_r = ($signed(a_v) > $signed(b_v)) ? a_v : b_v;
         smx_pkg::CMD_MIN: alu_r = ($signed(b_v) > $signed(a_v)) ? a_v : b_v;
         default:          alu_r = 64'd0 - a_v;
      endcase
   end

   // Shared 32 x 32 multiplier: low x low, low x high, high x low.
   assign mx    = (mcnt_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
   assign my    = (mcnt_ff == 2'd1) ? b_ff[63:32] : b_ff[31:0];
   assign mprod = {32'd0, mx} * {32'd0, my};

   always_comb begin
      state_in     = state_ff;
      tp_in        = tp_ff;
      top_in       = top_ff;
      cmd_in       = cmd_ff;
      opnd_in      = opnd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      base_in      = base_ff;
      err_in       = err_ff;
      mcnt_in      = mcnt_ff;
      acc_in       = acc_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      div_start    = 1'b0;
      commit       = 1'b0;
      commit_err   = smx_pkg::ERR_NONE;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_data.cmd;
               opnd_in  = req_data.operand;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            commit   = 1'b1;
            state_in = ST_IDLE;
            case (cmd_ff)
               smx_pkg::CMD_CONST: begin
                  if (tp_ff == FULL) begin
                     commit_err = smx_pkg::ERR_OVER;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(tp_ff);
                     wr_data = opnd_ff;
                     tp_in   = tp_ff + PW'(1);
                     top_in  = opnd_ff;
                  end
               end
               smx_pkg::CMD_ADD, smx_pkg::CMD_SUB,
               smx_pkg::CMD_MAX, smx_pkg::CMD_MIN: begin
                  wr_en      = 1'b1;
                  wr_addr    = AW'(base2);
                  wr_data    = alu_r;
                  tp_in      = base2 + PW'(1);
                  top_in     = alu_r;
                  commit_err = has2 ? smx_pkg::ERR_NONE : smx_pkg::ERR_UNDER;
               end
               smx_pkg::CMD_MUL: begin
                  commit   = 1'b0;
                  a_in     = a_v;
                  b_in     = b_v;
                  base_in  = base2;
                  err_in   = has2 ? smx_pkg::ERR_NONE : smx_pkg::ERR_UNDER;
                  mcnt_in  = '0;
                  state_in = ST_MUL;
               end
               smx_pkg::CMD_DIV: begin
                  if (b_v == 64'd0) begin
                     wr_en      = 1'b1;
                     wr_addr    = AW'(base2);
                     wr_data    = 64'd0;
                     tp_in      = base2 + PW'(1);
                     top_in     = 64'd0;
                     commit_err = smx_pkg::ERR_DIVZ;
                  end else begin
                     commit    = 1'b0;
                     div_start = 1'b1;
                     base_in   = base2;
                     err_in    = has2 ? smx_pkg::ERR_NONE : smx_pkg::ERR_UNDER;
                     state_in  = ST_DIV;
                  end
               end
               smx_pkg::CMD_NEG: begin
                  wr_en      = 1'b1;
                  wr_addr    = AW'(base1);
                  wr_data    = alu_r;
                  tp_in      = base1 + PW'(1);
                  top_in     = alu_r;
                  commit_err = has1 ? smx_pkg::ERR_NONE : smx_pkg::ERR_UNDER;
               end
               smx_pkg::CMD_DUP: begin
                  if (!has1) begin
                     commit_err = smx_pkg::ERR_UNDER;
                  end else if (tp_ff == FULL) begin
                     commit_err = smx_pkg::ERR_OVER;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(tp_ff);
                     wr_data = top_ff;
                     tp_in   = tp_ff + PW'(1);
                  end
               end
               smx_pkg::CMD_SWAP: begin
                  // The old top goes down first; the old second follows.
                  commit   = 1'b0;
                  wr_en    = 1'b1;
                  wr_addr  = AW'(base2);
                  wr_data  = a_v;
                  b_in     = b_v;
                  base_in  = base2;
                  err_in   = has2 ? smx_pkg::ERR_NONE : smx_pkg::ERR_UNDER;
                  state_in = ST_SWAP;
               end
               default: begin
                  commit_err = smx_pkg::ERR_NONE;
               end
            endcase
         end
         ST_MUL: begin
            mcnt_in = mcnt_ff + 2'd1;
            case (mcnt_ff)
               2'd0:    acc_in = mprod;
               2'd1,
               2'd2:    acc_in = {acc_ff[63:32] + mprod[31:0], acc_ff[31:0]};
               default: begin
                  commit     = 1'b1;
                  commit_err = err_ff;
                  wr_en      = 1'b1;
                  wr_addr    = AW'(base_ff);
                  wr_data    = acc_ff;
                  tp_in      = base_ff + PW'(1);
                  top_in     = acc_ff;
                  state_in   = ST_IDLE;
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               commit     = 1'b1;
               commit_err = err_ff;
               wr_en      = 1'b1;
               wr_addr    = AW'(base_ff);
               wr_data    = div_quo;
               tp_in      = base_ff + PW'(1);
               top_in     = div_quo;
               state_in   = ST_IDLE;
            end
         end
         ST_SWAP: begin
            commit     = 1'b1;
            commit_err = err_ff;
            wr_en      = 1'b1;
            wr_addr    = AW'(base_ff + PW'(1));
            wr_data    = b_ff;
            tp_in      = base_ff + PW'(2);
            top_in     = b_ff;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in         = commit;
      rsp_in.top_value     = (tp_in == '0) ? 64'sd0 : $signed(top_in);
      rsp_in.stack_depth   = DW'(tp_in);
      rsp_in.error_code    = commit_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         mcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         tp_ff        <= tp_in;
         rsp_valid_ff <= rsp_valid_in;
         mcnt_ff      <= mcnt_in;
      end
      top_ff  <= top_in;
      cmd_ff  <= cmd_in;
      opnd_ff <= opnd_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      base_ff <= base_in;
      err_ff  <= err_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not make the unit busy");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      tp_ff <= FULL)
      else $error("stack pointer beyond stack depth");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while an instruction is still executing");
`endif

endmodule

`default_nettype wire

@@ sv/smx_ram.sv @@
// -----------------------------------------------------------------------------
// smx_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module smx_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/smx_div.sv @@
// -----------------------------------------------------------------------------
// smx_div - iterative signed 64-bit divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// -----------------------------------------------------------------------------
`default_nettype none

module smx_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;
   logic [64:0] diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[63]};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend[63] ? (64'd0 - dividend) : dividend;
         den_in = divisor[63] ? (64'd0 - divisor) : divisor;
         neg_in = dividend[63] ^ divisor[63];
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[64]) begin
            rem_in = diff[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (64'd0 - quo_ff) : quo_ff;

endmodule

`default_nettype wire

@@ bench/smx_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// smx_checker - response checker of the stack machine execute unit
// Tracks a private copy of the operand stack, works out the response of each
// accepted request and compares it, all fields at once, with the block's responses.
// -----------------------------------------------------------------------------
`default_nettype none

module smx_checker
   import smx_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);

   logic [DATA_W-1:0] stack_copy [STACK_DEPTH];
   int                depth_copy;
   logic [ERR_W-1:0]  step_error;
   rsp_type           expected_rsps [$];

   assign pending_count = expected_rsps.size();

   function automatic void note_error(input logic [ERR_W-1:0] e);
      if (step_error == ERR_NONE) step_error = e;
   endfunction

   function automatic void push_entry(input logic [DATA_W-1:0] v);
      if (depth_copy >= STACK_DEPTH) begin
         note_error(ERR_OVER);
         return;
      end
      stack_copy[depth_copy] = v;
      depth_copy++;
   endfunction

   function automatic logic [DATA_W-1:0] pop_entry();
      if (depth_copy == 0) begin
         note_error(ERR_UNDER);
         return UNDERFLOW_VALUE;
      end
      depth_copy--;
      return stack_copy[depth_copy];
   endfunction

   function automatic rsp_type execute_request(input req_type rq);
      logic signed [DATA_W-1:0] a, b, r;
      rsp_type                  rs;
      step_error = ERR_NONE;
      case (rq.cmd)
         CMD_CONST: push_entry(rq.operand);
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MAX, CMD_MIN: begin
            a = pop_entry();
            b = pop_entry();
            case (rq.cmd)
               CMD_ADD: r = a + b;
               CMD_SUB: r = a - b;
               CMD_MUL: r = a * b;
               CMD_DIV: begin
                  if (b == 0) begin
                     note_error(ERR_DIVZ);
                     r = 0;
                  end else if (a == {1'b1, {(DATA_W-1){1'b0}}} && b == -1) begin
                     r = a;
                  end else begin
                     r = a / b;
                  end
               end
               CMD_MAX: r = (a > b) ? a : b;
               default: r = (b > a) ? a : b;
            endcase
            push_entry(r);
         end
         CMD_NEG: begin
            a = pop_entry();
            push_entry(-a);
         end
         CMD_DUP: begin
            if (depth_copy == 0) note_error(ERR_UNDER);
            else push_entry(stack_copy[depth_copy-1]);
         end
         CMD_SWAP: begin
            a = pop_entry();
            b = pop_entry();
            push_entry(a);
            push_entry(b);
         end
         default: ;
      endcase
      rs.top_value   = (depth_copy == 0) ? '0 : stack_copy[depth_copy-1];
      rs.stack_depth = depth_copy[DEPTH_W-1:0];
      rs.error_code  = step_error;
      return rs;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         depth_copy = 0;
         expected_rsps.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) expected_rsps.push_back(execute_request(req_data));
      end
   end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top - testbench of the stack machine execute unit
// Drives directed and random instruction streams, including stack underflow
// and division corner cases, while the checker predicts and compares every
// response.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import smx_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEFAULT;
   localparam longint CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   longint  cycle_count = 0;
   int      idle_percent;

   stack_machine_execute_unit_top #(.STACK_DEPTH(DEPTH)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   smx_checker #(.STACK_DEPTH(DEPTH)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The watchdog allows for the slowest legal run: every request a divide
   // with the sender's longest gaps, and a good margin on top.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Presents one request at the falling edge, then holds it until the block
   // takes it. Random idle cycles go in before it, according to the phase.
   // Busy only moves at rising edges, so the value seen at a falling edge
   // tells whether the next rising edge takes the request.
   task automatic send_request(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v);
      while ($urandom_range(99, 0) < idle_percent) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= {c, v};
      while (busy) @(negedge clock);
      @(negedge clock);
      start <= 1'b0;
      @(negedge clock);
   endtask

   // Operands favour the interesting corners: zero, plus and minus one, the
   // extremes and small values, with plain random words in between.
   function automatic logic [DATA_W-1:0] pick_operand();
      case ($urandom_range(7, 0))
         0: return 64'd0;
         1: return 64'd1;
         2: return '1;
         3: return {1'b1, 63'd0};
         4: return {1'b0, {63{1'b1}}};
         5: return 64'($signed($urandom_range(20, 0)) - 10);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Random stream: mostly well-formed work near a shallow stack, with some
   // unused codes and underflowing operations mixed in.
   task automatic random_requests(input int count);
      logic [CMD_W-1:0] c;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99, 0) < 35) c = CMD_CONST;
         else if ($urandom_range(99, 0) < 5) c = 4'($urandom_range(15, 10));
         else c = 4'($urandom_range(9, 1));
         send_request(c, pick_operand());
      end
   endtask

   initial begin
      idle_percent = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: ADD on an empty stack gives underflow, then DUP, NEG,
      // SWAP, an unused code, the division corners and the rest on extreme values.
      send_request(CMD_ADD, '0);
      send_request(CMD_DUP, '0);
      send_request(CMD_NEG, '0);
      send_request(CMD_SWAP, '0);
      send_request(4'd15, '1);
      send_request(CMD_CONST, 64'd0);
      send_request(CMD_CONST, 64'd5);
      send_request(CMD_DIV, '0);
      send_request(CMD_CONST, '1);
      send_request(CMD_CONST, {1'b1, 63'd0});
      send_request(CMD_DIV, '0);
      send_request(CMD_CONST, {1'b0, {63{1'b1}}});
      send_request(CMD_MUL, '0);
      send_request(CMD_CONST, 64'd7);
      send_request(CMD_SUB, '0);
      send_request(CMD_CONST, -64'sd3);
      send_request(CMD_MAX, '0);
      send_request(CMD_CONST, 64'd9);
      send_request(CMD_MIN, '0);
      send_request(CMD_DUP, '0);
      send_request(CMD_SWAP, '0);
      send_request(CMD_NEG, '0);

      // Random phases with different amounts of sender idling.
      idle_percent = 0;
      random_requests(170);
      idle_percent = 61;
      random_requests(170);
      // The sender holds back until every response has come back.
      while (pending_count != 0) @(negedge clock);
      idle_percent = 7;
      random_requests(150);
      idle_percent = 0;
      random_requests(150);

      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
